@@ src/cpb_pkg.sv @@
// Shared types and constants for the clipped premultiplied pixel blender.
`timescale 1ns / 1ps

package cpb_pkg;

    localparam int COORD_BITS = 16;

    localparam logic [1:0] MODE_FILL    = 2'd0;
    localparam logic [1:0] MODE_GLYPH   = 2'd1;
    localparam logic [1:0] MODE_TEXTURE = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clip_x0;
        logic signed [COORD_BITS-1:0] clip_y0;
        logic signed [COORD_BITS-1:0] clip_x1;
        logic signed [COORD_BITS-1:0] clip_y1;
        logic [31:0]                  fill_color;
        logic [23:0]                  tint_color;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [31:0]                  dest_pixel;
        logic [31:0]                  src_value;
    } pix_in_t;

    // Source terms ready for the blend stage
    typedef struct packed {
        logic        we;
        logic [7:0]  weight;
        logic [23:0] dst;
        logic [31:0] srb;
        logic [31:0] sg;
    } src_terms_t;

endpackage

@@ src/clipped_premultiplied_pixel_blender.sv @@
// Top level: three-register pixel pipeline with stream handshakes.
`timescale 1ns / 1ps

// Per-pixel blender for a 2D engine.
// Input stream (s_*): one pixel per item with mode, coordinate, destination
// pixel and source value. Output stream (m_*): one result per input item,
// write_enable and the new destination pixel (zero when no write).
// Configuration: cfg_wr_en/cfg_index/cfg_data write the clip window, fill
// color and glyph tint; write only while no pixel is in flight.
// Pipeline: input register, source term register (clip test and color
// multiply), result register (blend multiply and adds); a pixel passes
// through them in that order and then shows on m_tvalid.
// Throughput: one item per cycle while m_tready is high; each stage holds
// one item and moves on when the stage after it is empty or moving.
// Stall: when m_tready is low, results hold and the pipeline fills; s_tready
// falls once all three registers are full.
// Reset: all stages empty, clip window zero (every pixel clipped), fill
// color zero, tint white.

module clipped_premultiplied_pixel_blender
    import cpb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], pixel_x[17:2], pixel_y[33:18], dest_pixel[65:34],
    // src_value[97:66], zero pad[103:98]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // write_enable[0], pixel_out[32:1], zero pad[39:33]
    output logic [39:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t       cfg;
    pix_in_t    in_next;
    pix_in_t    in_reg;
    logic       in_valid_reg;
    src_terms_t terms_next;
    src_terms_t terms_reg;
    logic       terms_valid_reg;
    logic       res_we_next;
    logic [31:0] res_pix_next;
    logic       res_we_reg;
    logic [31:0] res_pix_reg;
    logic       res_valid_reg;
    logic       res_load;
    logic       terms_load;
    logic       in_load;

    cpb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_next.mode       = s_tdata[1:0];
    assign in_next.pixel_x    = s_tdata[17:2];
    assign in_next.pixel_y    = s_tdata[33:18];
    assign in_next.dest_pixel = s_tdata[65:34];
    assign in_next.src_value  = s_tdata[97:66];

    // A stage may load when it is empty or its item moves on this cycle
    assign res_load   = !res_valid_reg || m_tready;
    assign terms_load = !terms_valid_reg || res_load;
    assign in_load    = !in_valid_reg || terms_load;
    assign s_tready   = in_load;

    cpb_src u_src (
        .cfg   (cfg),
        .pix   (in_reg),
        .terms (terms_next)
    );

    cpb_blend u_blend (
        .terms        (terms_reg),
        .write_enable (res_we_next),
        .pixel_out    (res_pix_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            terms_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (terms_load)
            begin
                terms_valid_reg <= in_valid_reg;
            end
            if (res_load)
            begin
                res_valid_reg <= terms_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_tvalid)
        begin
            in_reg <= in_next;
        end
        if (terms_load && in_valid_reg)
        begin
            terms_reg <= terms_next;
        end
        if (res_load && terms_valid_reg)
        begin
            res_we_reg  <= res_we_next;
            res_pix_reg <= res_pix_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'b0, res_pix_reg, res_we_reg};

endmodule

@@ src/cpb_cfg.sv @@
// Configuration register file: clip window, fill color and glyph tint.
`timescale 1ns / 1ps

module cpb_cfg
    import cpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    localparam logic [2:0] REG_CLIP_X0 = 3'd0;
    localparam logic [2:0] REG_CLIP_Y0 = 3'd1;
    localparam logic [2:0] REG_CLIP_X1 = 3'd2;
    localparam logic [2:0] REG_CLIP_Y1 = 3'd3;
    localparam logic [2:0] REG_FILL    = 3'd4;
    localparam logic [2:0] REG_TINT    = 3'd5;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CLIP_X0: cfg_next.clip_x0    = cfg_data[COORD_BITS-1:0];
                REG_CLIP_Y0: cfg_next.clip_y0    = cfg_data[COORD_BITS-1:0];
                REG_CLIP_X1: cfg_next.clip_x1    = cfg_data[COORD_BITS-1:0];
                REG_CLIP_Y1: cfg_next.clip_y1    = cfg_data[COORD_BITS-1:0];
                REG_FILL:    cfg_next.fill_color = cfg_data;
                REG_TINT:    cfg_next.tint_color = cfg_data[23:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_x0    <= '0;
            cfg_reg.clip_y0    <= '0;
            cfg_reg.clip_x1    <= '0;
            cfg_reg.clip_y1    <= '0;
            cfg_reg.fill_color <= '0;
            cfg_reg.tint_color <= 24'hffffff;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/cpb_src.sv @@
// Clip test and per-mode source term generation (premultiplied color and weight).
`timescale 1ns / 1ps

module cpb_src
    import cpb_pkg::*;
(
    input  cfg_t       cfg,
    input  pix_in_t    pix,
    output src_terms_t terms
);

    logic        in_clip;
    logic [7:0]  factor;
    logic [7:0]  col_r;
    logic [7:0]  col_g;
    logic [7:0]  col_b;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    logic [31:0] mul_rb;
    logic [31:0] mul_g;
    logic [7:0]  src_alpha;

    assign in_clip = (pix.pixel_x >= cfg.clip_x0) && (pix.pixel_x < cfg.clip_x1) &&
                     (pix.pixel_y >= cfg.clip_y0) && (pix.pixel_y < cfg.clip_y1);

    // Fill uses its own alpha with the fill color, glyph uses coverage with the tint
    always_comb
    begin
        if (pix.mode == MODE_FILL)
        begin
            factor = cfg.fill_color[31:24];
            col_r  = cfg.fill_color[23:16];
            col_g  = cfg.fill_color[15:8];
            col_b  = cfg.fill_color[7:0];
        end
        else
        begin
            factor = pix.src_value[7:0];
            col_r  = cfg.tint_color[23:16];
            col_g  = cfg.tint_color[15:8];
            col_b  = cfg.tint_color[7:0];
        end
    end

    assign prod_r = ({8'h00, col_r} + 16'd1) * {8'h00, factor};
    assign prod_g = ({8'h00, col_g} + 16'd1) * {8'h00, factor};
    assign prod_b = ({8'h00, col_b} + 16'd1) * {8'h00, factor};

    assign mul_rb = {8'h00, prod_r[15:8], 8'h00, prod_b[15:8]};
    assign mul_g  = {16'h0000, prod_g[15:8], 8'h00};

    assign src_alpha = pix.src_value[31:24];

    always_comb
    begin
        terms.dst = pix.dest_pixel[23:0];
        unique case (pix.mode)
            MODE_FILL, MODE_GLYPH:
            begin
                terms.we     = in_clip && (factor != 8'h00);
                terms.weight = 8'hff - factor;
                terms.srb    = mul_rb;
                terms.sg     = mul_g;
            end
            MODE_TEXTURE:
            begin
                terms.we     = in_clip && (src_alpha != 8'h00);
                terms.weight = 8'hff - src_alpha;
                terms.srb    = pix.src_value & 32'h00ff00ff;
                terms.sg     = pix.src_value & 32'h0000ff00;
            end
            default:
            begin
                terms.we     = 1'b0;
                terms.weight = 8'h00;
                terms.srb    = '0;
                terms.sg     = '0;
            end
        endcase
    end

endmodule

@@ src/cpb_blend.sv @@
// Source-over blend of the destination with premultiplied source terms.
`timescale 1ns / 1ps

module cpb_blend
    import cpb_pkg::*;
(
    input  src_terms_t  terms,
    output logic        write_enable,
    output logic [31:0] pixel_out
);

    logic [15:0] dr_w;
    logic [15:0] dg_w;
    logic [15:0] db_w;
    logic [31:0] drb;
    logic [31:0] dg;
    logic [31:0] pix;

    assign dr_w = {8'h00, terms.dst[23:16]} * {8'h00, terms.weight};
    assign dg_w = {8'h00, terms.dst[15:8]}  * {8'h00, terms.weight};
    assign db_w = {8'h00, terms.dst[7:0]}   * {8'h00, terms.weight};

    // Carries wrap in 32 bits; they may reach the alpha byte
    assign drb = {8'h00, dr_w[15:8], 8'h00, db_w[15:8]} + terms.srb;
    assign dg  = {16'h0000, dg_w[15:8], 8'h00} + terms.sg;
    assign pix = drb + dg;

    assign write_enable = terms.we;
    assign pixel_out    = terms.we ? pix : 32'h0;

endmodule
